[hdl/bdtw_pkg.sv]
// bdtw_pkg: request/result types, state codes and fixed widths of the
// banded dtw offset matcher; no dependencies
package bdtw_pkg;

    // request and result payloads
    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  index;
        logic [15:0] sample;
    } t_req;

    typedef struct packed {
        logic [31:0] best_score;
        logic [1:0]  status;
    } t_result;

    // request kinds, the last one has no action
    localparam logic [1:0] KIND_LOAD_TMPL = 2'd0;
    localparam logic [1:0] KIND_LOAD_SIG  = 2'd1;
    localparam logic [1:0] KIND_START     = 2'd2;
    localparam logic [1:0] KIND_UNUSED    = 2'd3;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_SHORT_SIG = 2'd1;
    localparam logic [1:0] STATUS_NARROW    = 2'd2;

    // register indexes
    localparam logic [2:0] CFG_TMPL_LEN  = 3'd0;
    localparam logic [2:0] CFG_SIG_LEN   = 3'd1;
    localparam logic [2:0] CFG_BAND      = 3'd2;
    localparam logic [2:0] CFG_DTW_WT    = 3'd3;
    localparam logic [2:0] CFG_MAN_WT    = 3'd4;

    // cost infinity and score width
    localparam logic [31:0] COST_INF = 32'hFFFF_FFFF;
    localparam int          NUM_W    = 45;
    localparam int          DIVD_W   = NUM_W - 8;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_RD,
        ST_CALC,
        ST_MUL,
        ST_DIV,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

[hdl/bdtw_div.sv]
// bdtw_div: restoring divider, one quotient bit per cycle
// depends on bdtw_pkg for the dividend width
module bdtw_div #(
    parameter int VW = 9
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_go,
    input  logic [bdtw_pkg::DIVD_W-1:0] i_dividend,
    input  logic [VW-1:0]               i_divisor,
    output logic                        o_done,
    output logic [bdtw_pkg::DIVD_W-1:0] o_quotient
);
    import bdtw_pkg::*;

    localparam int CW = $clog2(DIVD_W + 1);

    logic [DIVD_W-1:0] r_q;
    logic [VW:0]       r_rem;
    logic [VW-1:0]     r_dvs;
    logic [CW-1:0]     r_cnt;
    logic              r_run;
    logic              r_done;
    logic [VW:0]       n_trial;
    logic              n_fit;

    // trial subtraction of one step
    always_comb begin
        n_trial = {r_rem[VW-1:0], r_q[DIVD_W-1]};
        n_fit   = (n_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= CW'(DIVD_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_run) begin
            r_rem <= n_fit ? (n_trial - {1'b0, r_dvs}) : n_trial;
            r_q   <= {r_q[DIVD_W-2:0], n_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

[hdl/banded_dtw_offset_matcher.sv]
// banded_dtw_offset_matcher: template/signal stores, band row memory and
// the cell sequencer; depends on bdtw_pkg and bdtw_div
//
// loads never raise busy; config writes always ready; no result stall
// a match walks every offset: per band cell a read and a calc state, per row a row read,
// and per offset a divider load, 37 divide steps plus a done state and a compare
// errors strobe the cycle after start; synchronous reset, config to defaults
module banded_dtw_offset_matcher #(
    parameter int MAX_TEMPLATE = 256,
    parameter int MAX_SIGNAL   = 512,
    parameter int MAX_BAND     = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  bdtw_pkg::t_req    i_req,
    output logic              o_done,
    output bdtw_pkg::t_result o_result,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [2:0]        i_cfg_index,
    input  logic [11:0]       i_cfg_data
);
    import bdtw_pkg::*;

    localparam int NW    = $clog2(MAX_TEMPLATE + 1);
    localparam int TAW   = $clog2(MAX_TEMPLATE);
    localparam int SW    = $clog2(MAX_SIGNAL + 1);
    localparam int SAW   = $clog2(MAX_SIGNAL);
    localparam int BW    = $clog2(MAX_BAND + 1);
    localparam int CELLS = 2 * MAX_BAND + 1;
    localparam int RAW   = $clog2(CELLS + 1);
    localparam int KW    = NW + 2;

    // configuration registers
    logic [8:0]  r_cfg_n;
    logic [9:0]  r_cfg_m;
    logic [4:0]  r_cfg_w;
    logic [11:0] r_cfg_dw;
    logic [11:0] r_cfg_mw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n  <= 9'd64;
            r_cfg_m  <= 10'd164;
            r_cfg_w  <= 5'd5;
            r_cfg_dw <= 12'd192;
            r_cfg_mw <= 12'd64;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TMPL_LEN: r_cfg_n  <= i_cfg_data[8:0];
                CFG_SIG_LEN:  r_cfg_m  <= i_cfg_data[9:0];
                CFG_BAND:     r_cfg_w  <= i_cfg_data[4:0];
                CFG_DTW_WT:   r_cfg_dw <= i_cfg_data;
                CFG_MAN_WT:   r_cfg_mw <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // saturated lengths
    logic [NW-1:0]  n_len;
    logic [SW-1:0]  m_len;
    logic [BW-1:0]  w_len;
    logic [RAW-1:0] last_j;

    always_comb begin
        n_len  = (32'(r_cfg_n) > MAX_TEMPLATE) ? NW'(MAX_TEMPLATE) : NW'(r_cfg_n);
        m_len  = (32'(r_cfg_m) > MAX_SIGNAL) ? SW'(MAX_SIGNAL) : SW'(r_cfg_m);
        w_len  = (32'(r_cfg_w) > MAX_BAND) ? BW'(MAX_BAND) : BW'(r_cfg_w);
        last_j = RAW'({w_len, 1'b0});
    end

    // sequencer registers
    t_state          r_state, n_state;
    logic [NW-1:0]   r_i;
    logic [RAW-1:0]  r_j;
    logic [SW-1:0]   r_p;
    logic [31:0]     r_left;
    logic [31:0]     r_pj;
    logic [31:0]     r_man;
    logic [31:0]     r_dtw;
    logic [31:0]     r_best;
    logic [1:0]      r_status;

    // memories
    logic [15:0] r_tmem [MAX_TEMPLATE];
    logic [15:0] r_smem [MAX_SIGNAL];
    logic [31:0] r_rmem [CELLS];
    logic [15:0] r_tq;
    logic [15:0] r_sq;
    logic [31:0] r_rq;

    logic              accept;
    logic signed [KW-1:0] n_k;
    logic              n_inband;
    logic [SAW-1:0]    s_addr;
    logic [RAW-1:0]    row_raddr;
    logic [16:0]       n_diff;
    logic [31:0]       n_d;
    logic [31:0]       n_pj1;
    logic [31:0]       n_bst;
    logic [32:0]       n_sum;
    logic [31:0]       n_val;
    logic [32:0]       n_msum;
    logic [31:0]       n_man;
    logic [NUM_W-1:0]  n_num;
    logic              div_go;
    logic              div_done;
    logic [DIVD_W-1:0] div_q;
    logic [31:0]       n_qsat;

    assign accept = i_start && (r_state == ST_IDLE);

    // band cell position and cost
    always_comb begin
        n_k      = $signed({2'b00, r_i}) - $signed(KW'(w_len)) + $signed(KW'(r_j));
        n_inband = (n_k >= 0) && (n_k < $signed({2'b00, n_len}));
        s_addr   = SAW'(r_p) + SAW'(n_k);
        row_raddr = (r_j == last_j) ? r_j : (r_j + 1'b1);
        n_diff   = {1'b0, r_tq} - {1'b0, r_sq};
        n_d      = 32'(n_diff[16] ? (r_sq - r_tq) : (r_tq - r_sq));
        n_pj1    = (r_j < last_j) ? r_rq : COST_INF;
        if (r_i == '0) begin
            n_bst = (n_k == 0) ? 32'd0 : r_left;
        end else begin
            n_bst = r_left;
            if (r_pj < n_bst) begin
                n_bst = r_pj;
            end
            if (n_pj1 < n_bst) begin
                n_bst = n_pj1;
            end
        end
        n_sum = {1'b0, n_bst} + {1'b0, n_d};
        if (!n_inband || n_bst == COST_INF) begin
            n_val = COST_INF;
        end else begin
            n_val = n_sum[32] ? COST_INF : n_sum[31:0];
        end
        n_msum = {1'b0, r_man} + {1'b0, n_d};
        n_man  = n_msum[32] ? COST_INF : n_msum[31:0];
        n_qsat = (|div_q[DIVD_W-1:32]) ? COST_INF : div_q[31:0];
    end

    // weighted sum of one offset, loaded into the divider
    always_comb begin
        n_num = NUM_W'(r_cfg_dw) * NUM_W'(r_dtw) + NUM_W'(r_cfg_mw) * NUM_W'(r_man);
    end

    // template and signal stores
    always_ff @(posedge i_clk) begin
        if (i_start && r_state == ST_IDLE && i_req.kind == KIND_LOAD_TMPL
            && 32'(i_req.index) < MAX_TEMPLATE) begin
            r_tmem[TAW'(i_req.index)] <= i_req.sample;
        end
        if (r_state == ST_RD) begin
            r_tq <= r_tmem[TAW'(r_i)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && r_state == ST_IDLE && i_req.kind == KIND_LOAD_SIG
            && 32'(i_req.index) < MAX_SIGNAL) begin
            r_smem[SAW'(i_req.index)] <= i_req.sample;
        end
        if (r_state == ST_RD) begin
            r_sq <= r_smem[s_addr];
        end
    end

    // band row memory, previous row overwritten in place
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CALC) begin
            r_rmem[r_j] <= n_val;
        end
        if (r_state == ST_ROW) begin
            r_rq <= r_rmem[0];
        end else if (r_state == ST_RD) begin
            r_rq <= r_rmem[row_raddr];
        end
    end

    // score divider
    assign div_go = (r_state == ST_MUL);

    bdtw_div #(
        .VW (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (div_go),
        .i_dividend (n_num[NUM_W-1:8]),
        .i_divisor  (n_len),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_req.kind == KIND_START) begin
                    if ({1'b0, n_len} <= (NW + 1)'({w_len, 1'b0})) begin
                        n_state = ST_DONE;
                    end else if (32'(m_len) < 32'(n_len)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_ROW;
                    end
                end
            end
            ST_ROW:  n_state = ST_RD;
            ST_RD:   n_state = ST_CALC;
            ST_CALC: begin
                if (r_j != last_j) begin
                    n_state = ST_RD;
                end else if (r_i == n_len - 1'b1) begin
                    n_state = ST_MUL;
                end else begin
                    n_state = ST_ROW;
                end
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_CMP;
                end
            end
            ST_CMP: begin
                if (32'(r_p) == 32'(m_len) - 32'(n_len)) begin
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_ROW;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best   <= COST_INF;
            r_status <= STATUS_OK;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept && i_req.kind == KIND_START) begin
                        r_best <= COST_INF;
                        if ({1'b0, n_len} <= (NW + 1)'({w_len, 1'b0})) begin
                            r_status <= STATUS_NARROW;
                        end else if (32'(m_len) < 32'(n_len)) begin
                            r_status <= STATUS_SHORT_SIG;
                        end else begin
                            r_status <= STATUS_OK;
                        end
                    end
                end
                ST_CMP: begin
                    if (n_qsat < r_best) begin
                        r_best <= n_qsat;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_p    <= '0;
                r_i    <= '0;
                r_j    <= '0;
                r_man  <= '0;
                r_left <= COST_INF;
            end
            ST_RD: begin
                if (r_j == '0) begin
                    r_pj <= r_rq;
                end
            end
            ST_CALC: begin
                r_pj <= r_rq;
                if (r_j == RAW'(w_len)) begin
                    r_man <= n_man;
                    if (r_i == n_len - 1'b1) begin
                        r_dtw <= n_val;
                    end
                end
                if (r_j == last_j) begin
                    r_j    <= '0;
                    r_left <= COST_INF;
                    r_i    <= r_i + 1'b1;
                end else begin
                    r_j    <= r_j + 1'b1;
                    r_left <= n_val;
                end
            end
            ST_CMP: begin
                r_p    <= r_p + 1'b1;
                r_i    <= '0;
                r_j    <= '0;
                r_man  <= '0;
                r_left <= COST_INF;
            end
            default: begin
            end
        endcase
    end

    // outputs
    assign o_busy              = (r_state != ST_IDLE);
    assign o_done              = (r_state == ST_DONE);
    assign o_result.best_score = r_best;
    assign o_result.status     = r_status;

endmodule

[sim/tb_banded_dtw_offset_matcher.sv]
// tb_banded_dtw_offset_matcher: self-checking testbench for the banded dtw offset matcher
// depends on bdtw_pkg and the banded_dtw_offset_matcher rtl
// checks every result strobe against an in-bench dtw and manhattan score predictor
module tb_banded_dtw_offset_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    import bdtw_pkg::*;

    localparam int TMPL_DEPTH = 256;
    localparam int SIG_DEPTH  = 512;
    localparam int BAND_MAX   = 16;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    t_req        req;
    logic        done;
    t_result     result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    // predictor copy of stores and registers
    logic [15:0] tmpl_mem [TMPL_DEPTH];
    logic [15:0] sig_mem  [SIG_DEPTH];
    int unsigned tmpl_len_reg;
    int unsigned sig_len_reg;
    int unsigned band_reg;
    int unsigned dtw_wt_reg;
    int unsigned man_wt_reg;

    t_result     score_queue [$];
    int          mismatch_count;
    int          result_count;
    int          request_count;
    int          match_count;
    bit          no_idle;

    banded_dtw_offset_matcher dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (req),
        .o_done      (done),
        .o_result    (result),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    initial begin
        #200_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [31:0] cost_add(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? COST_INF : s[31:0];
    endfunction

    function automatic logic [31:0] sample_dist(logic [15:0] a, logic [15:0] b);
        return (a > b) ? {16'd0, a - b} : {16'd0, b - a};
    endfunction

    // best weighted score over all offsets, plus status
    function automatic t_result predict_match();
        t_result           res;
        int unsigned       n, m, w, lastj;
        int                k;
        logic [31:0]       prev_row [2*BAND_MAX+1];
        logic [31:0]       cur_row  [2*BAND_MAX+1];
        logic [31:0]       cell_min, dtw, man;
        longint unsigned   num, q;
        n = (tmpl_len_reg > TMPL_DEPTH) ? TMPL_DEPTH : tmpl_len_reg;
        m = (sig_len_reg > SIG_DEPTH) ? SIG_DEPTH : sig_len_reg;
        w = (band_reg > BAND_MAX) ? BAND_MAX : band_reg;
        lastj = 2 * w;
        res.best_score = COST_INF;
        if (n <= 2 * w) begin
            res.status = STATUS_NARROW;
            return res;
        end
        if (m < n) begin
            res.status = STATUS_SHORT_SIG;
            return res;
        end
        res.status = STATUS_OK;
        for (int unsigned p = 0; p <= m - n; p++) begin
            // band rows, infinite outside the band and the template
            for (int unsigned i = 0; i < n; i++) begin
                for (int unsigned j = 0; j <= lastj; j++) begin
                    k = int'(i) - int'(w) + int'(j);
                    if (k < 0 || k >= int'(n)) begin
                        cur_row[j] = COST_INF;
                        continue;
                    end
                    cell_min = COST_INF;
                    if (j > 0 && cur_row[j-1] < cell_min) cell_min = cur_row[j-1];
                    if (i == 0) begin
                        if (k == 0) cell_min = 0;
                    end else begin
                        if (prev_row[j] < cell_min) cell_min = prev_row[j];
                        if (j < lastj && prev_row[j+1] < cell_min) cell_min = prev_row[j+1];
                    end
                    cur_row[j] = (cell_min == COST_INF) ? COST_INF :
                        cost_add(cell_min, sample_dist(tmpl_mem[i], sig_mem[p + k]));
                end
                for (int unsigned j = 0; j <= lastj; j++) prev_row[j] = cur_row[j];
            end
            dtw = prev_row[w];
            man = 0;
            for (int unsigned kk = 0; kk < n; kk++)
                man = cost_add(man, sample_dist(tmpl_mem[kk], sig_mem[p + kk]));
            num = longint'(dtw_wt_reg) * dtw + longint'(man_wt_reg) * man;
            q = num / (longint'(256) * n);
            if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
            if (q[31:0] < res.best_score) res.best_score = q[31:0];
        end
        return res;
    endfunction

    // send one request; start stays high on return so back-to-back needs no drop
    task automatic send_req(logic [1:0] kind, logic [8:0] idx, logic [15:0] smp);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 6);
        repeat (gap) begin
            @(negedge clk);
            start <= 1'b0;
            req   <= t_req'(27'($urandom));
        end
        @(negedge clk);
        start       <= 1'b1;
        req.kind    <= kind;
        req.index   <= idx;
        req.sample  <= smp;
        forever begin
            @(posedge clk);
            if (!busy) break;
        end
        request_count++;
        case (kind)
            KIND_LOAD_TMPL: if (idx < TMPL_DEPTH) tmpl_mem[idx] = smp;
            KIND_LOAD_SIG:  sig_mem[idx] = smp;
            KIND_START: begin
                score_queue.push_back(predict_match());
                match_count++;
            end
            default: ;
        endcase
    endtask

    // lower start and wait until every result is in and the block settles
    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (score_queue.size() != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // register write, only called after drain
    task automatic cfg_write(logic [2:0] idx, logic [11:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(posedge clk);
            if (cfg_ready) break;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TMPL_LEN: tmpl_len_reg = 32'(data[8:0]);
            CFG_SIG_LEN:  sig_len_reg  = 32'(data[9:0]);
            CFG_BAND:     band_reg     = 32'(data[4:0]);
            CFG_DTW_WT:   dtw_wt_reg   = 32'(data);
            CFG_MAN_WT:   man_wt_reg   = 32'(data);
            default: ;
        endcase
    endtask

    task automatic set_config(int unsigned n, int unsigned m, int unsigned w,
                              int unsigned dw, int unsigned mw);
        cfg_write(CFG_TMPL_LEN, 12'(n));
        cfg_write(CFG_SIG_LEN, 12'(m));
        cfg_write(CFG_BAND, 12'(w));
        cfg_write(CFG_DTW_WT, 12'(dw));
        cfg_write(CFG_MAN_WT, 12'(mw));
    endtask

    // fill stores up to the given lengths; mode 0 random, 1 alternating extremes
    task automatic load_stores(int unsigned n, int unsigned m, int mode);
        logic [15:0] v;
        for (int unsigned i = 0; i < n && i < TMPL_DEPTH; i++) begin
            v = (mode == 1) ? ((i % 2) ? 16'hFFFF : 16'h0000) : 16'($urandom);
            send_req(KIND_LOAD_TMPL, 9'(i), v);
        end
        for (int unsigned i = 0; i < m && i < SIG_DEPTH; i++) begin
            v = (mode == 1) ? ((i % 2) ? 16'h0000 : 16'hFFFF) : 16'($urandom);
            send_req(KIND_LOAD_SIG, 9'(i), v);
        end
    endtask

    // result checker
    always @(posedge clk) begin
        t_result exp_res;
        if (rst_n && done) begin
            result_count++;
            if (score_queue.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result score=%h status=%0d",
                             result.best_score, result.status);
            end else begin
                exp_res = score_queue.pop_front();
                if (result.best_score !== exp_res.best_score ||
                    result.status !== exp_res.status) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp score=%h status=%0d got score=%h status=%0d",
                                 exp_res.best_score, exp_res.status,
                                 result.best_score, result.status);
                end
            end
        end
    end

    // reset values, ignored kinds and out-of-range template loads
    task automatic test_defaults();
        load_stores(64, 164, 0);
        send_req(KIND_START, 9'd0, 16'd0);
        send_req(KIND_UNUSED, 9'd5, 16'hFFFF);
        send_req(KIND_LOAD_TMPL, 9'd256, 16'h1234);
        send_req(KIND_LOAD_TMPL, 9'd511, 16'hABCD);
        send_req(KIND_START, 9'h1FF, 16'hFFFF);
        drain();
    endtask

    // error statuses, zero band and weight extremes
    task automatic test_errors();
        set_config(0, 10, 5, 192, 64);
        send_req(KIND_START, 9'd0, 16'd0);
        drain();
        set_config(10, 20, 5, 192, 64);
        send_req(KIND_START, 9'd0, 16'd0);
        drain();
        set_config(11, 10, 5, 192, 64);
        send_req(KIND_START, 9'd0, 16'd0);
        drain();
        set_config(1, 1, 0, 0, 0);
        send_req(KIND_START, 9'd0, 16'd0);
        drain();
        set_config(5, 9, 0, 4095, 4095);
        load_stores(5, 9, 1);
        send_req(KIND_START, 9'd0, 16'd0);
        drain();
    endtask

    // oversized registers saturate; largest template and signal
    task automatic test_extremes();
        set_config(511, 260, 31, 4095, 4095);
        load_stores(256, 260, 1);
        send_req(KIND_START, 9'd0, 16'd0);
        drain();
        // template head is already loaded, only the signal tail is missing
        set_config(3, 1023, 1, 4095, 0);
        for (int unsigned i = 260; i < SIG_DEPTH; i++)
            send_req(KIND_LOAD_SIG, 9'(i), 16'($urandom));
        send_req(KIND_START, 9'd0, 16'd0);
        drain();
    endtask

    // random phases: config, full loads with some noise, then one or more matches
    task automatic test_random();
        int unsigned n, m, w;
        while (request_count < 1000 || match_count < 24) begin
            no_idle = ($urandom_range(0, 3) == 0);
            w = $urandom_range(0, 3);
            n = $urandom_range(1, 12);
            m = ($urandom_range(0, 5) == 0) ? $urandom_range(1, n) : $urandom_range(n, n + 20);
            set_config(n, m, w, $urandom_range(0, 4095), $urandom_range(0, 4095));
            load_stores(n, m, ($urandom_range(0, 7) == 0) ? 1 : 0);
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1))
                    send_req(KIND_UNUSED, 9'($urandom), 16'($urandom));
                else
                    send_req(KIND_LOAD_TMPL, 9'($urandom_range(256, 511)), 16'($urandom));
            end
            repeat ($urandom_range(1, 2)) send_req(KIND_START, 9'($urandom), 16'($urandom));
            if ($urandom_range(0, 1)) begin
                send_req(KIND_LOAD_SIG, 9'($urandom_range(0, m - 1)), 16'($urandom));
                send_req(KIND_START, 9'd0, 16'd0);
            end
            drain();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        rst_n          = 1'b0;
        start          = 1'b0;
        req            = '0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        mismatch_count = 0;
        result_count   = 0;
        request_count  = 0;
        match_count    = 0;
        no_idle        = 1'b0;
        tmpl_len_reg   = 64;
        sig_len_reg    = 164;
        band_reg       = 5;
        dtw_wt_reg     = 192;
        man_wt_reg     = 64;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_defaults();
        test_errors();
        test_extremes();
        test_random();
        drain();

        $display("run: %0d requests accepted, %0d matches started, %0d results checked",
                 request_count, match_count, result_count);
        $display("run: %0d mismatches", mismatch_count);
        if (mismatch_count == 0 && score_queue.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
